// File: rtl/core/rmq_pkg.sv
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ELEM_W        = 16;
    localparam int ELEM_CNT      = 9;
    localparam int IN_W          = ELEM_W * ELEM_CNT;
    localparam int QW_W          = 15;
    localparam int OUT_W         = 64;
    localparam int LANES         = 4;
    localparam int MAG_MAX       = 32767;

    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    typedef struct packed {
        logic neg_z;
        logic neg_y;
        logic neg_x;
    } sign_t;

endpackage

// File: rtl/core/rmq_prep.sv
module rmq_prep
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SQ_W      = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [IN_W-1:0]                      in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [LANES-1:0][2*SQ_W-1:0]         out_rad,
    output sign_t                                out_sign
);

    localparam int RAD_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int UR_W  = RAD_W - 1;
    localparam logic [RAD_W-1:0] ONE = RAD_W'(64'd1 << FRAC_BITS);

    function automatic logic [RAD_W-1:0] sext(input logic [ELEM_W-1:0] e);
        sext = {{(RAD_W-ELEM_W){e[ELEM_W-1]}}, e};
    endfunction

    logic [RAD_W-1:0]                 a00;
    logic [RAD_W-1:0]                 a11;
    logic [RAD_W-1:0]                 a22;
    logic [LANES-1:0][RAD_W-1:0]      rad;
    logic [LANES-1:0][2*SQ_W-1:0]     rad_n;
    logic [ELEM_W:0]                  dx;
    logic [ELEM_W:0]                  dy;
    logic [ELEM_W:0]                  dz;
    logic                             en;
    logic                             valid_reg;
    logic                             valid_next;
    logic [LANES-1:0][2*SQ_W-1:0]     rad_reg;
    sign_t                            sign_reg;

    always_comb
    begin
        a00 = sext(in_data[0*ELEM_W +: ELEM_W]);
        a11 = sext(in_data[4*ELEM_W +: ELEM_W]);
        a22 = sext(in_data[8*ELEM_W +: ELEM_W]);
        rad[LANE_W] = ONE + a00 + a11 + a22;
        rad[LANE_X] = ONE + a00 - a11 - a22;
        rad[LANE_Y] = ONE - a00 + a11 - a22;
        rad[LANE_Z] = ONE - a00 - a11 + a22;
        for (int i = 0; i < LANES; i++)
        begin
            if (rad[i][RAD_W-1])
            begin
                rad_n[i] = '0;
            end
            else
            begin
                rad_n[i] = (2*SQ_W)'(rad[i][UR_W-1:0]) << FRAC_BITS;
            end
        end
        dx = {in_data[7*ELEM_W+ELEM_W-1], in_data[7*ELEM_W +: ELEM_W]}
           - {in_data[5*ELEM_W+ELEM_W-1], in_data[5*ELEM_W +: ELEM_W]};
        dy = {in_data[2*ELEM_W+ELEM_W-1], in_data[2*ELEM_W +: ELEM_W]}
           - {in_data[6*ELEM_W+ELEM_W-1], in_data[6*ELEM_W +: ELEM_W]};
        dz = {in_data[3*ELEM_W+ELEM_W-1], in_data[3*ELEM_W +: ELEM_W]}
           - {in_data[1*ELEM_W+ELEM_W-1], in_data[1*ELEM_W +: ELEM_W]};
    end

    assign en         = !valid_reg || out_ready;
    assign in_ready   = en;
    assign valid_next = en ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            rad_reg        <= rad_n;
            sign_reg.neg_x <= dx[ELEM_W];
            sign_reg.neg_y <= dy[ELEM_W];
            sign_reg.neg_z <= dz[ELEM_W];
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_sign  = sign_reg;

endmodule

// File: rtl/core/rmq_cell.sv
module rmq_cell
    import rmq_pkg::*;
#(
    parameter int SQ_W = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [LANES-1:0][2*SQ_W-1:0]     in_rad,
    input  logic [LANES-1:0][SQ_W+1:0]       in_rem,
    input  logic [LANES-1:0][SQ_W-1:0]       in_root,
    input  sign_t                            in_sign,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [LANES-1:0][2*SQ_W-1:0]     out_rad,
    output logic [LANES-1:0][SQ_W+1:0]       out_rem,
    output logic [LANES-1:0][SQ_W-1:0]       out_root,
    output sign_t                            out_sign
);

    localparam int REM_W = SQ_W + 2;
    localparam int CAT_W = REM_W + 2;

    logic [LANES-1:0][CAT_W-1:0]      cat;
    logic [LANES-1:0][CAT_W-1:0]      trial;
    logic [LANES-1:0]                 ge;
    logic [LANES-1:0][2*SQ_W-1:0]     rad_n;
    logic [LANES-1:0][REM_W-1:0]      rem_n;
    logic [LANES-1:0][SQ_W-1:0]       root_n;
    logic                             en;
    logic                             valid_reg;
    logic                             valid_next;
    logic [LANES-1:0][2*SQ_W-1:0]     rad_reg;
    logic [LANES-1:0][REM_W-1:0]      rem_reg;
    logic [LANES-1:0][SQ_W-1:0]       root_reg;
    sign_t                            sign_reg;

    // One bit of the root per cell: bring down two radicand bits and try 4q+1.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            cat[i]    = {in_rem[i], in_rad[i][2*SQ_W-1 -: 2]};
            trial[i]  = CAT_W'({in_root[i], 2'b01});
            ge[i]     = cat[i] >= trial[i];
            rem_n[i]  = ge[i] ? REM_W'(cat[i] - trial[i]) : REM_W'(cat[i]);
            root_n[i] = {in_root[i][SQ_W-2:0], ge[i]};
            rad_n[i]  = in_rad[i] << 2;
        end
    end

    assign en         = !valid_reg || out_ready;
    assign in_ready   = en;
    assign valid_next = en ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            rad_reg  <= rad_n;
            rem_reg  <= rem_n;
            root_reg <= root_n;
            sign_reg <= in_sign;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_sign  = sign_reg;

endmodule

// File: rtl/core/rmq_post.sv
module rmq_post
    import rmq_pkg::*;
#(
    parameter int SQ_W = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LANES-1:0][SQ_W-1:0]    in_root,
    input  sign_t                         in_sign,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [OUT_W-1:0]              out_data
);

    localparam int MW = ((SQ_W - 1) > ELEM_W) ? (SQ_W - 1) : ELEM_W;

    logic [LANES-1:0][MW-1:0]      mag_ext;
    logic [LANES-1:0][QW_W-1:0]    mag;
    logic [LANES-1:0][ELEM_W-1:0]  mag_s;
    logic [ELEM_W-1:0]             qx;
    logic [ELEM_W-1:0]             qy;
    logic [ELEM_W-1:0]             qz;
    logic                          en;
    logic                          valid_reg;
    logic                          valid_next;
    logic [OUT_W-1:0]              data_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mag_ext[i] = MW'(in_root[i] >> 1);
            if (mag_ext[i] > MW'(MAG_MAX))
            begin
                mag[i] = QW_W'(MAG_MAX);
            end
            else
            begin
                mag[i] = mag_ext[i][QW_W-1:0];
            end
            mag_s[i] = {1'b0, mag[i]};
        end
        qx = in_sign.neg_x ? (ELEM_W'(0) - mag_s[LANE_X]) : mag_s[LANE_X];
        qy = in_sign.neg_y ? (ELEM_W'(0) - mag_s[LANE_Y]) : mag_s[LANE_Y];
        qz = in_sign.neg_z ? (ELEM_W'(0) - mag_s[LANE_Z]) : mag_s[LANE_Z];
    end

    assign en         = !valid_reg || out_ready;
    assign in_ready   = en;
    assign valid_next = en ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= OUT_W'({qz, qy, qx, mag[LANE_W]});
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/rotation_matrix_to_quaternion_core.sv
// Structure: one register stage forms the radicands, one cell per root bit
// follows, and one stage saturates and applies the signs.
// Throughput: one word per cycle; each stage holds its word until the next frees.
// Reset: rst_n clears every stage's valid flag asynchronously; data is not reset.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // quat_w (15), quat_x (16), quat_y (16), quat_z (16), one zero pad bit
    output logic [OUT_W-1:0]   m_tdata
);

    localparam int RAD_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int NW    = RAD_W - 1 + FRAC_BITS;
    localparam int SQ_W  = (NW + 1) / 2;
    localparam int NCELL = SQ_W;

    logic [NCELL:0]                             v_c;
    logic [NCELL:0]                             r_c;
    logic [NCELL:0][LANES-1:0][2*SQ_W-1:0]      rad_c;
    logic [NCELL:0][LANES-1:0][SQ_W+1:0]        rem_c;
    logic [NCELL:0][LANES-1:0][SQ_W-1:0]        root_c;
    sign_t [NCELL:0]                            sign_c;

    rmq_prep #(
        .FRAC_BITS (FRAC_BITS),
        .SQ_W      (SQ_W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (v_c[0]),
        .out_ready (r_c[0]),
        .out_rad   (rad_c[0]),
        .out_sign  (sign_c[0])
    );

    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        rmq_cell #(
            .SQ_W (SQ_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_c[g]),
            .in_ready  (r_c[g]),
            .in_rad    (rad_c[g]),
            .in_rem    (rem_c[g]),
            .in_root   (root_c[g]),
            .in_sign   (sign_c[g]),
            .out_valid (v_c[g+1]),
            .out_ready (r_c[g+1]),
            .out_rad   (rad_c[g+1]),
            .out_rem   (rem_c[g+1]),
            .out_root  (root_c[g+1]),
            .out_sign  (sign_c[g+1])
        );
    end

    rmq_post #(
        .SQ_W (SQ_W)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_c[NCELL]),
        .in_ready  (r_c[NCELL]),
        .in_root   (root_c[NCELL]),
        .in_sign   (sign_c[NCELL]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// File: rtl/core/rmq_checker.sv
module rmq_checker
    import rmq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tready,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_W-1:0]   m_tdata
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    // A free output stage frees every stage behind it in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled although the output is free");

    // The pad bit is zero and no signed part reaches the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_W-1] == 1'b0) && (m_tdata[30:15] != 16'h8000)
                     && (m_tdata[46:31] != 16'h8000) && (m_tdata[62:47] != 16'h8000))
        else $error("result word out of range");

    // A word held by a stall keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rmq_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int ONE_Q       = 1 << FRAC;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 580;
    localparam int MAX_PRINTED = 40;

    typedef logic [ELEM_CNT-1:0][ELEM_W-1:0] matrix_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] z;
        logic signed [ELEM_W-1:0] y;
        logic signed [ELEM_W-1:0] x;
        logic [QW_W-1:0]          w;
    } quat_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    matrix_t matrix_pending [$];
    quat_t   quat_expected [$];
    int      errors = 0;
    int      send_idle = 35;
    int      recv_idle = 63;
    int      hold_req = 0;
    int      hold_served;
    int      hold_left;
    int      stall_cycles = 0;

    rotation_matrix_to_quaternion_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint int_sqrt(input longint n);
        longint r;
        longint t;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic longint half_root(input longint rad);
        longint mag;
        mag = (rad < 0) ? 0 : (int_sqrt(rad << FRAC) >> 1);
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        return mag;
    endfunction

    function automatic logic [ELEM_W-1:0] apply_sign(input longint mag, input longint diff);
        longint v;
        v = (diff < 0) ? -mag : mag;
        return v[ELEM_W-1:0];
    endfunction

    // The matrix is indexed row by row, so entry (r, c) sits at 3 * r + c.
    function automatic quat_t matrix_to_quat(input matrix_t mat);
        longint e [ELEM_CNT];
        longint one;
        quat_t  q;
        one = longint'(ONE_Q);
        for (int i = 0; i < ELEM_CNT; i++)
            e[i] = longint'($signed(mat[i]));
        q.w = QW_W'(half_root(one + e[0] + e[4] + e[8]));
        q.x = apply_sign(half_root(one + e[0] - e[4] - e[8]), e[7] - e[5]);
        q.y = apply_sign(half_root(one - e[0] + e[4] - e[8]), e[2] - e[6]);
        q.z = apply_sign(half_root(one - e[0] - e[4] + e[8]), e[3] - e[1]);
        return q;
    endfunction

    function automatic logic [ELEM_W-1:0] to_fixed(input real v);
        int k;
        k = $rtoi(v * real'(ONE_Q) + ((v >= 0.0) ? 0.5 : -0.5));
        if (k > 32767)
            k = 32767;
        if (k < -32768)
            k = -32768;
        return k[ELEM_W-1:0];
    endfunction

    function automatic real unit_rand();
        return ($urandom_range(0, 2000000) / 1000000.0) - 1.0;
    endfunction

    function automatic logic [ELEM_W-1:0] edge_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'shffff;
            3: return 16'sh0000;
            4: return 16'sh0001;
            5: return ELEM_W'(ONE_Q);
            6: return ELEM_W'(-ONE_Q);
            default: return ELEM_W'(ONE_Q - 1);
        endcase
    endfunction

    // Builds a proper rotation from a random unit quaternion, with a little jitter now and then.
    function automatic matrix_t random_rotation();
        real     qw, qx, qy, qz, norm, jitter;
        real     r [ELEM_CNT];
        matrix_t mat;
        do
        begin
            qw = unit_rand();
            qx = unit_rand();
            qy = unit_rand();
            qz = unit_rand();
            norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        end
        while (norm < 0.05);
        qw = qw / norm;
        qx = qx / norm;
        qy = qy / norm;
        qz = qz / norm;
        r[0] = 1.0 - 2.0 * (qy * qy + qz * qz);
        r[1] = 2.0 * (qx * qy - qw * qz);
        r[2] = 2.0 * (qx * qz + qw * qy);
        r[3] = 2.0 * (qx * qy + qw * qz);
        r[4] = 1.0 - 2.0 * (qx * qx + qz * qz);
        r[5] = 2.0 * (qy * qz - qw * qx);
        r[6] = 2.0 * (qx * qz - qw * qy);
        r[7] = 2.0 * (qy * qz + qw * qx);
        r[8] = 1.0 - 2.0 * (qx * qx + qy * qy);
        for (int i = 0; i < ELEM_CNT; i++)
        begin
            jitter = 0.0;
            if ($urandom_range(0, 3) == 0)
                jitter = (real'($urandom_range(0, 8)) - 4.0) / real'(ONE_Q);
            mat[i] = to_fixed(r[i] + jitter);
        end
        return mat;
    endfunction

    function automatic matrix_t random_matrix();
        int      sel;
        matrix_t mat;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            mat = random_rotation();
        else if (sel < 80)
        begin
            for (int i = 0; i < ELEM_CNT; i++)
                mat[i] = ELEM_W'($urandom());
        end
        else if (sel < 90)
        begin
            for (int i = 0; i < ELEM_CNT; i++)
                mat[i] = edge_value();
        end
        else
        begin
            mat = random_rotation();
            case ($urandom_range(0, 2))
                0: mat[7] = mat[5];
                1: mat[2] = mat[6];
                default: mat[3] = mat[1];
            endcase
        end
        return mat;
    endfunction

    task automatic queue_matrix(input int a00, input int a01, input int a02,
                                input int a10, input int a11, input int a12,
                                input int a20, input int a21, input int a22);
        matrix_t mat;
        mat[0] = a00[ELEM_W-1:0];
        mat[1] = a01[ELEM_W-1:0];
        mat[2] = a02[ELEM_W-1:0];
        mat[3] = a10[ELEM_W-1:0];
        mat[4] = a11[ELEM_W-1:0];
        mat[5] = a12[ELEM_W-1:0];
        mat[6] = a20[ELEM_W-1:0];
        mat[7] = a21[ELEM_W-1:0];
        mat[8] = a22[ELEM_W-1:0];
        matrix_pending.push_back(mat);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (matrix_pending.size() != 0 || s_tvalid || quat_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                quat_expected.push_back(matrix_to_quat(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (matrix_pending.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= matrix_pending.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        quat_t got;
        quat_t want;
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_left   <= 0;
            hold_served <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(quat_t)-1:0];
                if (quat_expected.size() == 0)
                    report("result word with no conversion outstanding");
                else
                begin
                    want = quat_expected.pop_front();
                    if (got.w !== want.w)
                        report($sformatf("quat_w got %0d want %0d", got.w, want.w));
                    if (got.x !== want.x)
                        report($sformatf("quat_x got %0d want %0d", got.x, want.x));
                    if (got.y !== want.y)
                        report($sformatf("quat_y got %0d want %0d", got.y, want.y));
                    if (got.z !== want.z)
                        report($sformatf("quat_z got %0d want %0d", got.z, want.z));
                end
            end
            if (hold_served != hold_req)
            begin
                hold_served <= hold_req;
                hold_left   <= HOLD_CYCLES;
                m_tready    <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_matrix(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q);
        queue_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        queue_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        queue_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);
        queue_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
        queue_matrix(ONE_Q, 0, 0, 0, 0, -ONE_Q, 0, ONE_Q, 0);
        queue_matrix(ONE_Q, 0, 0, 0, 0, ONE_Q, 0, -ONE_Q, 0);
        queue_matrix(0, 0, ONE_Q, 0, ONE_Q, 0, -ONE_Q, 0, 0);
        queue_matrix(0, 0, -ONE_Q, 0, ONE_Q, 0, ONE_Q, 0, 0);
        queue_matrix(0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q);
        queue_matrix(0, ONE_Q, 0, -ONE_Q, 0, 0, 0, 0, ONE_Q);
        queue_matrix(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q);
        queue_matrix(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q);
        queue_matrix(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q);
        queue_matrix(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0);
        queue_matrix(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0);
        queue_matrix(32767, -1, -1, -1, -32768, -1, -1, -1, 32767);
        queue_matrix(-32768, 5, -5, -5, 32767, 5, 5, -5, -32768);
        queue_matrix(-ONE_Q, 0, 0, 0, 0, 0, 0, 0, -1);
        repeat (PHASE_ITEMS) matrix_pending.push_back(random_matrix());
        wait_drained();

        send_idle = 63;
        recv_idle = 35;
        repeat (PHASE_ITEMS) matrix_pending.push_back(random_matrix());
        wait_drained();

        // The output is held off at the start of this phase so that the pipeline backs up.
        send_idle = 0;
        recv_idle = 0;
        hold_req++;
        repeat (PHASE_ITEMS) matrix_pending.push_back(random_matrix());
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && quat_expected.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_prep.sv
rtl/core/rmq_cell.sv
rtl/core/rmq_post.sv
rtl/core/rotation_matrix_to_quaternion_core.sv
rtl/core/rmq_checker.sv
verif/testbench.sv
